/* sv/mme_pkg.sv */
// Package for the matrix multiply engine: command codes, field widths,
// parameter defaults and the pipeline tag and result types.
// No dependencies.
package mme_pkg;

   // Field widths fixed by the item format
   localparam int CMD_W  = 2;
   localparam int IDX_W  = 3;
   localparam int DATA_W = 32;

   // Default matrix dimensions
   localparam int ROWS_DEF  = 4;
   localparam int INNER_DEF = 4;
   localparam int COLS_DEF  = 4;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_WRITE_FIRST  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_SECOND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MULTIPLY     = 2'd2;

   // Tag that travels with each multiply-accumulate term
   typedef struct packed {
      logic             vld;
      logic             first;
      logic             last_k;
      logic             a_ok;
      logic             b_ok;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             last_elem;
   } mme_tag_type;

   // Finished product element from the datapath
   typedef struct packed {
      logic              vld;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [DATA_W-1:0] product;
      logic              last;
   } mme_res_type;

endpackage

/* sv/mme_if.sv */
// Valid/ready channel interfaces for command items and product items.
// Depends on mme_pkg.
interface mme_req_if import mme_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic [IDX_W-1:0]         row;
   logic [IDX_W-1:0]         col;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, command, row, col, value, input ready);
   modport sink   (input valid, command, row, col, value, output ready);
endinterface

interface mme_rsp_if import mme_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [IDX_W-1:0]         out_row;
   logic [IDX_W-1:0]         out_col;
   logic signed [DATA_W-1:0] product;
   logic                     last;

   modport source (output valid, out_row, out_col, product, last, input ready);
   modport sink   (input valid, out_row, out_col, product, last, output ready);
endinterface

/* sv/mme_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/mme_mac.sv */
// Multiply-accumulate datapath: multiplies the two read operands, then
// accumulates the terms of one product element. Depends on mme_pkg.
module mme_mac import mme_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  mme_tag_type       issue_tag,
   input  logic [DATA_W-1:0] a_rdata,
   input  logic [DATA_W-1:0] b_rdata,
   output mme_res_type       res
);

   mme_tag_type       tag1_ff, tag2_ff;
   logic [DATA_W-1:0] opa, opb;
   logic [DATA_W-1:0] prod_in, prod_ff;
   logic [DATA_W-1:0] acc_in, acc_ff;

   // Align the tag with the RAM read data, then with the product
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else begin
         tag1_ff <= issue_tag;
         tag2_ff <= tag1_ff;
      end
   end

   // Entries never written read as zero
   assign opa     = tag1_ff.a_ok ? a_rdata : '0;
   assign opb     = tag1_ff.b_ok ? b_rdata : '0;
   // Keep the low word of the product: wraps modulo 2^32
   assign prod_in = opa * opb;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Restart the sum on the first term, otherwise add on
   assign acc_in = tag2_ff.first ? prod_ff : acc_ff + prod_ff;

   always_ff @(posedge clock) begin
      if (tag2_ff.vld) begin
         acc_ff <= acc_in;
      end
   end

   // Hand out the element on its final term
   assign res.vld     = tag2_ff.vld && tag2_ff.last_k;
   assign res.row     = tag2_ff.row;
   assign res.col     = tag2_ff.col;
   assign res.product = acc_in;
   assign res.last    = tag2_ff.last_elem;

endmodule

/* sv/matrix_multiply_engine.sv */
// Integer matrix multiply engine. Load items write one element of the
// first (ROWS x INNER) or second (INNER x COLS) matrix; writes outside the
// matrix and unused command codes are dropped. A multiply item streams
// the ROWS*COLS product elements in row-major order, the final one flagged
// by last. Each element is summed by the single multiply-accumulate unit,
// which reads one word from each matrix memory per cycle while it issues
// the terms of that element; the next element starts only once the last
// one has been taken at the output. No new item is taken until the last
// element has been delivered. Both matrices read as zero after reset
// through per-entry valid bits, so no clearing pass is needed. Depends on
// mme_pkg, mme_if, mme_ram, mme_mac.
module matrix_multiply_engine import mme_pkg::*; #(
   parameter int ROWS  = ROWS_DEF,
   parameter int INNER = INNER_DEF,
   parameter int COLS  = COLS_DEF
) (
   input logic        clock,
   input logic        reset,
   mme_req_if.sink    req_ch,
   mme_rsp_if.source  rsp_ch
);

   localparam int A_DEPTH = ROWS * INNER;
   localparam int B_DEPTH = INNER * COLS;
   localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
   localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [IDX_W-1:0]   i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [A_DEPTH-1:0] a_vld_ff;
   logic [B_DEPTH-1:0] b_vld_ff;

   logic               req_fire, rsp_fire;
   logic               a_we, b_we;
   logic [A_AW-1:0]    a_wr_addr, a_rd_addr;
   logic [B_AW-1:0]    b_wr_addr, b_rd_addr;
   logic [DATA_W-1:0]  a_rdata, b_rdata;
   logic               last_k, last_elem;

   mme_tag_type        issue_tag;
   mme_res_type        res;

   logic               rsp_vld_ff;
   logic [IDX_W-1:0]   rsp_row_ff, rsp_col_ff;
   logic [DATA_W-1:0]  rsp_prod_ff;
   logic               rsp_last_ff;

   // Handshakes
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_fire     = rsp_vld_ff && rsp_ch.ready;

   // Load decode with bounds check
   assign a_we = req_fire && (req_ch.command == CMD_WRITE_FIRST)
                 && (32'(req_ch.row) < ROWS) && (32'(req_ch.col) < INNER);
   assign b_we = req_fire && (req_ch.command == CMD_WRITE_SECOND)
                 && (32'(req_ch.row) < INNER) && (32'(req_ch.col) < COLS);
   assign a_wr_addr = A_AW'(32'(req_ch.row) * INNER + 32'(req_ch.col));
   assign b_wr_addr = B_AW'(32'(req_ch.row) * COLS + 32'(req_ch.col));

   // Operand addresses for the current term
   assign a_rd_addr = A_AW'(32'(i_ff) * INNER + 32'(k_ff));
   assign b_rd_addr = B_AW'(32'(k_ff) * COLS + 32'(j_ff));

   // Mark entries written since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= '0;
         b_vld_ff <= '0;
      end else begin
         if (a_we) begin
            a_vld_ff[a_wr_addr] <= 1'b1;
         end
         if (b_we) begin
            b_vld_ff[b_wr_addr] <= 1'b1;
         end
      end
   end

   // Matrix stores; writes happen only while idle, so they never overlap the operand reads
   mme_ram #(.WIDTH(DATA_W), .DEPTH(A_DEPTH)) u_first_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_wr_addr),
      .wr_data ($unsigned(req_ch.value)),
      .rd_addr (a_rd_addr),
      .rd_data (a_rdata)
   );

   mme_ram #(.WIDTH(DATA_W), .DEPTH(B_DEPTH)) u_second_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_wr_addr),
      .wr_data ($unsigned(req_ch.value)),
      .rd_addr (b_rd_addr),
      .rd_data (b_rdata)
   );

   assign last_k    = (k_ff == IDX_W'(INNER - 1));
   assign last_elem = (i_ff == IDX_W'(ROWS - 1)) && (j_ff == IDX_W'(COLS - 1));

   // Tag the term being read this cycle
   always_comb begin
      issue_tag           = '0;
      issue_tag.vld       = (state_ff == ST_ISSUE);
      issue_tag.first     = (k_ff == '0);
      issue_tag.last_k    = last_k;
      issue_tag.a_ok      = a_vld_ff[a_rd_addr];
      issue_tag.b_ok      = b_vld_ff[b_rd_addr];
      issue_tag.row       = i_ff;
      issue_tag.col       = j_ff;
      issue_tag.last_elem = last_elem;
   end

   // Sequencer: issue INNER terms, wait for the element to leave, advance
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_ch.command == CMD_MULTIPLY)) begin
               state_in = ST_ISSUE;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
            end
         end
         ST_ISSUE: begin
            if (last_k) begin
               state_in = ST_DRAIN;
               k_in     = '0;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (rsp_fire) begin
               if (last_elem) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_ISSUE;
                  if (j_ff == IDX_W'(COLS - 1)) begin
                     j_in = '0;
                     i_in = i_ff + 1'b1;
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   mme_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .issue_tag (issue_tag),
      .a_rdata   (a_rdata),
      .b_rdata   (b_rdata),
      .res       (res)
   );

   // Output register: load a finished element, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (res.vld) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_fire) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res.vld) begin
         rsp_row_ff  <= res.row;
         rsp_col_ff  <= res.col;
         rsp_prod_ff <= res.product;
         rsp_last_ff <= res.last;
      end
   end

   assign rsp_ch.valid   = rsp_vld_ff;
   assign rsp_ch.out_row = rsp_row_ff;
   assign rsp_ch.out_col = rsp_col_ff;
   assign rsp_ch.product = $signed(rsp_prod_ff);
   assign rsp_ch.last    = rsp_last_ff;

endmodule

/* sv/mme_checker.sv */
// Port-level checks for the matrix multiply engine, bound to the top level.
// Depends on mme_pkg, mme_if and matrix_multiply_engine.
module mme_checker import mme_pkg::*; (
   input logic        clock,
   input logic        reset,
   mme_req_if.sink    req_ch,
   mme_rsp_if.source  rsp_ch
);

   // A stalled product item stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid)
      else $error("product item withdrawn while stalled");

   // Commands are only taken with the output side empty
   assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("command side ready while a product item waits");

   // A multiply keeps the command side closed on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && (req_ch.command == CMD_MULTIPLY)
      |=> !req_ch.ready)
      else $error("command taken straight after a multiply");

   // More elements follow a non-final one
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && !rsp_ch.last |=> !req_ch.ready)
      else $error("engine went idle before the final element");

   // The final element frees the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && rsp_ch.last |=> req_ch.ready)
      else $error("engine not idle after the final element");

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (
   .clock  (clock),
   .reset  (reset),
   .req_ch (req_ch),
   .rsp_ch (rsp_ch)
);
